// ===== rtl/grns_pkg.sv =====
package grns_pkg;

    localparam int GRID_W_DEF = 256;
    localparam int GRID_H_DEF = 256;
    localparam int MAX_K_DEF  = 16;

    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 9;
    localparam int SC_W     = 12;
    localparam int RING_W   = 10;
    localparam int OWNER_W  = 16;
    localparam int WANTED_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_PLACE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [WANTED_W-1:0] WANTED_RESET = 5'd8;
    localparam logic [OWNER_W-1:0]  COUNT_FULL   = 16'hFFFF;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } in_word_t;

    typedef struct packed {
        logic [OWNER_W-1:0] neighbour;
        logic               last;
        logic               short_run;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic clear_start;
        logic clear_step;
        logic place;
        logic setup;
        logic load_cell;
        logic advance;
        logic push;
        logic final_emit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic search_done;
        logic cell_in;
        logic cell_hit;
        logic push_ok;
        logic slot_free;
    } status_t;

endpackage

// ===== rtl/grns_ram.sv =====
module grns_ram
    import grns_pkg::*;
#(
    parameter int WIDTH = OWNER_W,
    parameter int DEPTH = GRID_W_DEF * GRID_H_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/grns_datapath.sv =====
module grns_datapath
    import grns_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF,
    parameter int MAX_K  = MAX_K_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  in_word_t            in_word,
    input  logic                cfg_write_en,
    input  logic [WANTED_W-1:0] cfg_write_data,
    input  logic                out_ready,
    output logic                out_valid,
    output out_word_t           out_word
);

    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int K_W    = $clog2(MAX_K + 1);

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    localparam logic signed [SC_W-1:0] S_ONE = SC_W'(1);

    typedef logic [ADDR_W-1:0] addr_t;

    logic [COORD_W-1:0]  x_reg, y_reg, ext_x_reg, ext_y_reg, cx_reg, cy_reg;
    logic [OWNER_W-1:0]  count_reg, pend_reg;
    logic [WANTED_W-1:0] wanted_reg;
    logic [RING_W-1:0]   dmax_reg, d_reg, dk_reg;
    logic [RING_W-1:0]   dmax_next;
    logic [1:0]          e_reg;
    logic [K_W-1:0]      m_reg, k_eff;
    logic                pend_valid_reg, out_valid_reg;
    out_word_t           out_word_reg;
    addr_t               clr_reg, addr_calc, wr_addr;
    logic [COORD_W-1:0]  row, col;
    logic                wr_en, place_ok, last_dk;
    logic [OWNER_W-1:0]  wr_data, rd_data;

    logic signed [SC_W-1:0] xs, ys, ds, dks, exs, eys, px, py;
    logic signed [SC_W-1:0] c0, c1, c2, c3, mx;

    assign xs  = $signed({{(SC_W-COORD_W){1'b0}}, x_reg});
    assign ys  = $signed({{(SC_W-COORD_W){1'b0}}, y_reg});
    assign exs = $signed({{(SC_W-COORD_W){1'b0}}, ext_x_reg});
    assign eys = $signed({{(SC_W-COORD_W){1'b0}}, ext_y_reg});
    assign ds  = $signed({{(SC_W-RING_W){1'b0}}, d_reg});
    assign dks = $signed({{(SC_W-RING_W){1'b0}}, dk_reg});

    always_comb
    begin
        case (e_reg)
            EDGE_TOP:
            begin
                px = xs - ds + dks;
                py = ys - ds;
            end
            EDGE_RIGHT:
            begin
                px = xs + ds;
                py = ys - ds + dks;
            end
            EDGE_BOTTOM:
            begin
                px = xs + ds - dks;
                py = ys + ds;
            end
            default:
            begin
                px = xs - ds;
                py = ys + ds - dks;
            end
        endcase
    end

    // furthest ring that can still reach a cell inside the extents
    always_comb
    begin
        c0 = xs - S_ONE;
        c1 = exs - xs;
        c2 = ys - S_ONE;
        c3 = eys - ys;
        mx = '0;
        if (c0 > mx)
        begin
            mx = c0;
        end
        if (c1 > mx)
        begin
            mx = c1;
        end
        if (c2 > mx)
        begin
            mx = c2;
        end
        if (c3 > mx)
        begin
            mx = c3;
        end
        if (ext_x_reg == '0 || ext_y_reg == '0)
        begin
            mx = '0;
        end
        dmax_next = mx[RING_W-1:0];
    end

    always_comb
    begin
        if (wanted_reg == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (int'(wanted_reg) > MAX_K)
        begin
            k_eff = K_W'(MAX_K);
        end
        else
        begin
            k_eff = K_W'(wanted_reg);
        end
    end

    assign last_dk  = ({1'b0, dk_reg} == ({d_reg, 1'b0} - 1'b1));
    assign place_ok = (x_reg != '0) && (y_reg != '0) && (int'(x_reg) <= GRID_W)
                   && (int'(y_reg) <= GRID_H) && (count_reg != COUNT_FULL);

    assign row       = cmd.place ? y_reg : cy_reg;
    assign col       = cmd.place ? x_reg : cx_reg;
    assign addr_calc = addr_t'(row - 1'b1) * addr_t'(GRID_W) + addr_t'(col - 1'b1);

    assign wr_en   = cmd.clear_step || (cmd.place && place_ok);
    assign wr_addr = cmd.clear_step ? clr_reg : addr_calc;
    assign wr_data = cmd.clear_step ? '0 : count_reg + 1'b1;

    grns_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_calc),
        .rd_data (rd_data)
    );

    assign status.clear_last  = (clr_reg == addr_t'(DEPTH - 1));
    assign status.search_done = (d_reg > dmax_reg) || (m_reg >= k_eff);
    assign status.cell_in     = (px > 0) && (py > 0) && (px <= exs) && (py <= eys);
    assign status.cell_hit    = (rd_data != '0);
    assign status.slot_free   = !out_valid_reg || out_ready;
    assign status.push_ok     = !pend_valid_reg || status.slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg     <= WANTED_RESET;
            clr_reg        <= '0;
            ext_x_reg      <= '0;
            ext_y_reg      <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                wanted_reg <= cfg_write_data;
            end
            if (cmd.clear_start)
            begin
                clr_reg   <= '0;
                ext_x_reg <= '0;
                ext_y_reg <= '0;
                count_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            else if (cmd.place && place_ok)
            begin
                count_reg <= count_reg + 1'b1;
                if (x_reg > ext_x_reg)
                begin
                    ext_x_reg <= x_reg;
                end
                if (y_reg > ext_y_reg)
                begin
                    ext_y_reg <= y_reg;
                end
            end
            if (cmd.setup)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            if ((cmd.push && pend_valid_reg) || cmd.final_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= in_word.x;
            y_reg <= in_word.y;
        end
        if (cmd.setup)
        begin
            dmax_reg <= dmax_next;
            d_reg    <= RING_W'(1);
            dk_reg   <= '0;
            e_reg    <= EDGE_TOP;
            m_reg    <= '0;
        end
        else if (cmd.advance)
        begin
            if (e_reg == EDGE_LEFT)
            begin
                e_reg <= EDGE_TOP;
                if (last_dk)
                begin
                    dk_reg <= '0;
                    d_reg  <= d_reg + 1'b1;
                end
                else
                begin
                    dk_reg <= dk_reg + 1'b1;
                end
            end
            else
            begin
                e_reg <= e_reg + 1'b1;
            end
        end
        if (cmd.load_cell)
        begin
            cx_reg <= px[COORD_W-1:0];
            cy_reg <= py[COORD_W-1:0];
        end
        if (cmd.push)
        begin
            pend_reg <= rd_data;
            m_reg    <= m_reg + 1'b1;
            if (pend_valid_reg)
            begin
                out_word_reg.neighbour <= pend_reg;
                out_word_reg.last      <= 1'b0;
                out_word_reg.short_run <= 1'b0;
            end
        end
        else if (cmd.final_emit)
        begin
            out_word_reg.neighbour <= pend_valid_reg ? pend_reg : '0;
            out_word_reg.last      <= 1'b1;
            out_word_reg.short_run <= (m_reg < k_eff);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== rtl/grns_ctrl.sv =====
module grns_ctrl
    import grns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    input  status_t           status,
    output cmd_t              cmd,
    output logic              in_ready
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PLACE = 8'b0000_0100,
        S_SETUP = 8'b0000_1000,
        S_CALC  = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_FINAL = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (in_func)
                        FUNC_PLACE: state_next = S_PLACE;
                        FUNC_QUERY: state_next = S_SETUP;
                        FUNC_CLEAR:
                        begin
                            cmd.clear_start = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_IDLE;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (status.search_done)
                begin
                    state_next = S_FINAL;
                end
                else if (status.cell_in)
                begin
                    cmd.load_cell = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.advance = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                // on a hit, hold while both the output and the pending word are occupied
                if (!status.cell_hit)
                begin
                    state_next = S_CALC;
                end
                else if (status.push_ok)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_FINAL:
            begin
                if (status.slot_free)
                begin
                    cmd.final_emit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/grid_ring_neighbour_search.sv =====
// Ring search for the nearest occupied cells of an occupancy grid.
// Input words (in_valid/in_ready) carry func, x and y: place writes the next
// probe index at (x,y), clear empties the grid, query returns the indices of
// the nearest occupied cells, ring by ring. Output words (out_valid/out_ready)
// carry neighbour, last and short_run; only a query produces output words.
// neighbours_wanted is written through cfg_write_en/cfg_write_data (reset 8).
// One item is in work at a time; in_ready is high only between items.
// Clear, and reset, run a clearing pass over all GRID_W*GRID_H cells of the
// grid memory (65536 at the defaults) with in_ready low. A query passes
// through S_SETUP, then for each ring cell S_CALC alone if the cell lies
// outside the extents, or S_CALC, S_READ and S_CHECK if it lies inside
// them, and ends in S_FINAL, so its length follows probe density.
// A found index is held one step back so that the final word can be marked;
// while the receiver stalls, the search holds on the next hit until the
// output register frees. The next item is taken while the last word waits.
module grid_ring_neighbour_search
    import grns_pkg::*;
#(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF,
    parameter int MAX_K  = MAX_K_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output out_word_t           out_word,
    input  logic                cfg_write_en,
    input  logic [WANTED_W-1:0] cfg_write_data
);

    cmd_t    cmd;
    status_t status;

    grns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_word.func),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    grns_datapath #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .MAX_K  (MAX_K)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_word        (in_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_word       (out_word)
    );

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_word.func != FUNC_UNUSED |=> !in_ready)
        else $error("item accepted but block did not go busy");

    a_final_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_emit |-> status.slot_free)
        else $error("final word issued over an occupied output");

    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.short_run |-> out_word.last)
        else $error("short_run set on a word that is not last");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !in_ready)
        else $error("input ready during clearing pass");

endmodule

// ===== verif/grid_ring_neighbour_search_tb.sv =====
`timescale 1ns / 1ps

module grid_ring_neighbour_search_tb
    import grns_pkg::*;
;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_LEN    = 300;
    localparam int GRID_CELLS  = GRID_W_DEF * GRID_H_DEF;

    localparam out_word_t NONE_FOUND = '{neighbour: 16'd0, last: 1'b1, short_run: 1'b1};
    localparam out_word_t NO_WORD    = '0;

    typedef struct packed {
        logic                set_wanted;
        logic [WANTED_W-1:0] wanted;
        logic [FUNC_W-1:0]   func;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                typed;
        out_word_t           want_word;
    } step_row_t;

    step_row_t plan [24] = '{
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd511, 9'd511, 1'b1, NONE_FOUND},
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd0,   9'd0,   1'b1, NONE_FOUND},
        '{1'b0, 5'd0,  FUNC_UNUSED, 9'd511, 9'd511, 1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd0,   9'd5,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd5,   9'd0,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd257, 9'd3,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd3,   9'd511, 1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd1,   9'd1,   1'b1, NONE_FOUND},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd1,   9'd1,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd3,   9'd1,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd2,   9'd3,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd2,   9'd2,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd1,   9'd1,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd2,   9'd2,   1'b0, NO_WORD},
        '{1'b1, 5'd1,  FUNC_QUERY,  9'd2,   9'd2,   1'b0, NO_WORD},
        '{1'b1, 5'd0,  FUNC_QUERY,  9'd1,   9'd1,   1'b0, NO_WORD},
        '{1'b1, 5'd31, FUNC_QUERY,  9'd3,   9'd3,   1'b0, NO_WORD},
        '{1'b1, 5'd16, FUNC_QUERY,  9'd1,   9'd3,   1'b0, NO_WORD},
        '{1'b1, 5'd1,  FUNC_PLACE,  9'd256, 9'd256, 1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd257, 9'd257, 1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_PLACE,  9'd255, 9'd256, 1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd256, 9'd256, 1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_CLEAR,  9'd511, 9'd0,   1'b0, NO_WORD},
        '{1'b0, 5'd0,  FUNC_QUERY,  9'd256, 9'd256, 1'b1, NONE_FOUND}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_word_t            in_word;
    logic                out_valid;
    logic                out_ready;
    out_word_t           out_word;
    logic                cfg_write_en;
    logic [WANTED_W-1:0] cfg_write_data;

    logic [OWNER_W-1:0]  owner_copy [GRID_CELLS];
    int                  span_x;
    int                  span_y;
    int                  placed;
    logic [WANTED_W-1:0] wanted_reg;
    out_word_t           due_words [$];
    out_word_t           oldest;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_trigger;
    bit hold_seen;
    int hold_left;
    int errors;
    int cycles;

    grid_ring_neighbour_search dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_word_t pack_item(input logic [FUNC_W-1:0] func, input int x,
                                           input int y);
        in_word_t w;
        w.func = func;
        w.x    = COORD_W'(x);
        w.y    = COORD_W'(y);
        return w;
    endfunction

    task automatic wipe_grid();
        foreach (owner_copy[i])
            owner_copy[i] = '0;
        span_x = 0;
        span_y = 0;
        placed = 0;
    endtask

    task automatic apply_and_search(input in_word_t w);
        int                 qx;
        int                 qy;
        int                 k;
        int                 dmax;
        int                 d;
        int                 dk;
        int                 e;
        int                 cx;
        int                 cy;
        logic [OWNER_W-1:0] hit;
        logic [OWNER_W-1:0] hits [$];
        out_word_t          ow;
        qx = int'(w.x);
        qy = int'(w.y);
        case (w.func)
            FUNC_CLEAR:
            begin
                wipe_grid();
            end
            FUNC_PLACE:
            begin
                if (qx >= 1 && qy >= 1 && qx <= GRID_W_DEF && qy <= GRID_H_DEF
                    && placed < int'(COUNT_FULL))
                begin
                    placed++;
                    owner_copy[(qx - 1) + (qy - 1) * GRID_W_DEF] = OWNER_W'(placed);
                    if (qx > span_x)
                        span_x = qx;
                    if (qy > span_y)
                        span_y = qy;
                end
            end
            FUNC_QUERY:
            begin
                k = int'(wanted_reg);
                if (k < 1)
                    k = 1;
                if (k > MAX_K_DEF)
                    k = MAX_K_DEF;
                dmax = 0;
                if (span_x != 0 && span_y != 0)
                begin
                    if (qx - 1 > dmax)
                        dmax = qx - 1;
                    if (span_x - qx > dmax)
                        dmax = span_x - qx;
                    if (qy - 1 > dmax)
                        dmax = qy - 1;
                    if (span_y - qy > dmax)
                        dmax = span_y - qy;
                end
                for (d = 1; d <= dmax && hits.size() < k; d++)
                    for (dk = 0; dk < 2 * d && hits.size() < k; dk++)
                        for (e = 0; e < 4 && hits.size() < k; e++)
                        begin
                            case (e)
                                0:
                                begin
                                    cx = qx - d + dk;
                                    cy = qy - d;
                                end
                                1:
                                begin
                                    cx = qx + d;
                                    cy = qy - d + dk;
                                end
                                2:
                                begin
                                    cx = qx + d - dk;
                                    cy = qy + d;
                                end
                                default:
                                begin
                                    cx = qx - d;
                                    cy = qy + d - dk;
                                end
                            endcase
                            if (cx >= 1 && cy >= 1 && cx <= span_x && cy <= span_y)
                            begin
                                hit = owner_copy[(cx - 1) + (cy - 1) * GRID_W_DEF];
                                if (hit != '0)
                                    hits.push_back(hit);
                            end
                        end
                if (hits.size() == 0)
                    due_words.push_back(NONE_FOUND);
                else
                    foreach (hits[i])
                    begin
                        ow.neighbour = hits[i];
                        ow.last      = (i == hits.size() - 1);
                        ow.short_run = ow.last && (hits.size() < k);
                        due_words.push_back(ow);
                    end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_item(input in_word_t w, input bit typed = 1'b0,
                             input out_word_t typed_word = '0);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            due_words.push_back(typed_word);
        else
            apply_and_search(w);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0 || !in_ready)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_wanted(input logic [WANTED_W-1:0] v);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        wanted_reg = v;
    endtask

    task automatic random_phase(input int wanted_items);
        int       taken;
        int       pick;
        int       bad;
        in_word_t w;
        taken = 0;
        while (taken < wanted_items)
        begin
            pick = $urandom_range(0, 99);
            bad  = $urandom_range(257, 512);
            if (bad == 512)
                bad = 0;
            if (pick < 50)
            begin
                w = pack_item(FUNC_PLACE, $urandom_range(1, 12), $urandom_range(1, 12));
                taken++;
            end
            else if (pick < 82)
            begin
                w = pack_item(FUNC_QUERY, $urandom_range(0, 14), $urandom_range(0, 14));
                taken++;
            end
            else if (pick < 91)
            begin
                if ($urandom_range(0, 1) == 0)
                    w = pack_item(FUNC_PLACE, bad, $urandom_range(0, 511));
                else
                    w = pack_item(FUNC_PLACE, $urandom_range(1, 256), bad);
            end
            else
            begin
                w = pack_item(FUNC_UNUSED, $urandom_range(0, 511), $urandom_range(0, 511));
            end
            push_item(w);
        end
        push_item(pack_item(FUNC_QUERY, $urandom_range(1, 12), $urandom_range(1, 12)));
    endtask

    initial
    begin
        out_ready = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_words.size() == 0)
            begin
                $error("unexpected word: neighbour %0d, last %0d, short_run %0d",
                       out_word.neighbour, out_word.last, out_word.short_run);
                errors++;
            end
            else
            begin
                oldest = due_words.pop_front();
                if (out_word.neighbour !== oldest.neighbour)
                begin
                    $error("neighbour: expected %0d, got %0d", oldest.neighbour,
                           out_word.neighbour);
                    errors++;
                end
                if (out_word.last !== oldest.last)
                begin
                    $error("last: expected %0d, got %0d", oldest.last, out_word.last);
                    errors++;
                end
                if (out_word.short_run !== oldest.short_run)
                begin
                    $error("short_run: expected %0d, got %0d", oldest.short_run,
                           out_word.short_run);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        errors         = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_word        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        hold_trigger   = 1'b0;
        send_idle_pct  = 25;
        recv_idle_pct  = 77;
        wanted_reg     = WANTED_RESET;
        wipe_grid();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        settle();

        foreach (plan[i])
        begin
            if (plan[i].set_wanted)
                write_wanted(plan[i].wanted);
            push_item(pack_item(plan[i].func, int'(plan[i].x), int'(plan[i].y)),
                      plan[i].typed, plan[i].want_word);
        end

        write_wanted(WANTED_W'($urandom_range(1, 16)));
        random_phase(50);

        send_idle_pct = 77;
        recv_idle_pct = 25;
        write_wanted(WANTED_W'($urandom_range(0, 31)));
        push_item(pack_item(FUNC_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511)));
        random_phase(50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_wanted(5'd16);
        push_item(pack_item(FUNC_CLEAR, 0, 0));
        settle();
        // hold the receiver off so the block backs up onto its input
        hold_trigger = ~hold_trigger;
        random_phase(50);

        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
